// ===== src/mhtq_pkg.sv =====
// ----------------------------------------------------------------------------
// mhtq_pkg
// Shared types and constants of the min-heap timer queue.
// ----------------------------------------------------------------------------
package mhtq_pkg;

  localparam int DEF_CAPACITY = 64;
  localparam int DEF_ID_COUNT = 256;
  localparam int MAX_RESULTS  = 64;

  localparam int EXP_W   = 32;
  localparam int ID_W    = 8;
  localparam int DELAY_W = 16;
  localparam int IDLE_W  = 16;

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 48;

  localparam logic [IDLE_W-1:0] IDLE_PERIOD_RST = 16'd5;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_TICK   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    CMD_IDLE,
    CMD_LOAD,
    CMD_SET_FULL,
    CMD_ADD_START,
    CMD_UP_READ,
    CMD_UP_MOVE,
    CMD_UP_PLACE,
    CMD_CANCEL,
    CMD_TK_START,
    CMD_TOP_READ,
    CMD_POP,
    CMD_DN_LOAD,
    CMD_DN_READ,
    CMD_DN_MOVE,
    CMD_DN_PLACE,
    CMD_TK_FIN
  } cmd_t;

  // Separate command for emission phase, issued alongside cmd_t.
  typedef enum logic [1:0] {
    EM_NONE,
    EM_BUF_READ,
    EM_RESP,
    EM_FIRED
  } em_cmd_t;

  typedef struct packed {
    op_t  op;
    logic full;
    logic pos_zero;
    logic up_stop;
    logic count_zero;
    logic pop_ok;
    logic child_exists;
    logic dn_move;
    logic n_zero;
    logic em_last;
    logic out_free;
  } dp_stat_t;

  typedef struct packed {
    logic [EXP_W-1:0] expiry;
    logic [ID_W-1:0]  id;
  } heap_entry_t;

endpackage

// ===== src/mhtq_ctrl.sv =====
// ----------------------------------------------------------------------------
// mhtq_ctrl
// Sequencer for add, cancel and tick: drives the datapath one step a cycle, holding while the result register is full.
// ----------------------------------------------------------------------------
module mhtq_ctrl
  import mhtq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  dp_stat_t stat,
  output cmd_t     cmd,
  output em_cmd_t  em_cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_UP_RD,
    S_UP_CMP,
    S_TK_RD,
    S_TK_CHK,
    S_DN_LOAD,
    S_DN_RD,
    S_DN_CMP,
    S_EM_START,
    S_EM_RD,
    S_EM_OUT,
    S_RESP
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_IDLE;
    em_cmd    = EM_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd       = CMD_LOAD;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat.op)
          OP_ADD: begin
            if (stat.full) begin
              cmd       = CMD_SET_FULL;
              state_nxt = S_RESP;
            end else begin
              cmd       = CMD_ADD_START;
              state_nxt = S_UP_RD;
            end
          end
          OP_CANCEL: begin
            cmd       = CMD_CANCEL;
            state_nxt = S_RESP;
          end
          OP_TICK: begin
            cmd       = CMD_TK_START;
            state_nxt = S_TK_RD;
          end
          OP_NONE: state_nxt = S_RESP;
          default: state_nxt = S_RESP;
        endcase
      end
      S_UP_RD: begin
        if (stat.pos_zero) begin
          cmd       = CMD_UP_PLACE;
          state_nxt = S_RESP;
        end else begin
          cmd       = CMD_UP_READ;
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (stat.up_stop) begin
          cmd       = CMD_UP_PLACE;
          state_nxt = S_RESP;
        end else begin
          cmd       = CMD_UP_MOVE;
          state_nxt = S_UP_RD;
        end
      end
      S_TK_RD: begin
        cmd       = CMD_TOP_READ;
        state_nxt = S_TK_CHK;
      end
      S_TK_CHK: begin
        if (stat.pop_ok) begin
          cmd       = CMD_POP;
          state_nxt = S_DN_LOAD;
        end else begin
          cmd       = CMD_TK_FIN;
          state_nxt = S_EM_START;
        end
      end
      S_DN_LOAD: begin
        // The pop emptied the heap: nothing is left to sift.
        if (stat.count_zero) begin
          state_nxt = S_TK_RD;
        end else begin
          cmd       = CMD_DN_LOAD;
          state_nxt = S_DN_RD;
        end
      end
      S_DN_RD: begin
        if (stat.child_exists) begin
          cmd       = CMD_DN_READ;
          state_nxt = S_DN_CMP;
        end else begin
          cmd       = CMD_DN_PLACE;
          state_nxt = S_TK_RD;
        end
      end
      S_DN_CMP: begin
        if (stat.dn_move) begin
          cmd       = CMD_DN_MOVE;
          state_nxt = S_DN_RD;
        end else begin
          cmd       = CMD_DN_PLACE;
          state_nxt = S_TK_RD;
        end
      end
      S_EM_START: begin
        state_nxt = stat.n_zero ? S_RESP : S_EM_RD;
      end
      S_EM_RD: begin
        em_cmd    = EM_BUF_READ;
        state_nxt = S_EM_OUT;
      end
      S_EM_OUT: begin
        if (stat.out_free) begin
          em_cmd    = EM_FIRED;
          state_nxt = stat.em_last ? S_IDLE : S_EM_RD;
        end
      end
      S_RESP: begin
        if (stat.out_free) begin
          em_cmd    = EM_RESP;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== src/mhtq_datapath.sv =====
// ----------------------------------------------------------------------------
// mhtq_datapath
// Heap memory, cancel flags, fired-id buffer and the result register.
// ----------------------------------------------------------------------------
module mhtq_datapath
  import mhtq_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY,
  parameter int ID_COUNT = DEF_ID_COUNT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  cfg_wr_en,
  input  logic [IDLE_W-1:0]     cfg_wr_data,
  input  cmd_t                  cmd,
  input  em_cmd_t               em_cmd,
  output dp_stat_t              stat,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast
);

  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CW     = IDX_W + 2;
  localparam int FLAG_N = (ID_COUNT < 256) ? ID_COUNT : 256;
  localparam int FLAG_W = $clog2(FLAG_N);
  localparam int RES_W  = $clog2(MAX_RESULTS + 1);
  localparam int BUF_AW = $clog2(MAX_RESULTS);

  heap_entry_t heap_mem [CAPACITY];
  logic [ID_W-1:0] buf_mem [MAX_RESULTS];

  logic [1:0]         op_r;
  logic [EXP_W-1:0]   now_r;
  logic [DELAY_W-1:0] delay_r;
  logic [ID_W-1:0]    id_r;
  logic               full_r;
  logic [EXP_W-1:0]   nd_r;
  logic [IDLE_W-1:0]  idle_period_r;
  logic [CNT_W-1:0]   count_r;
  logic [IDX_W-1:0]   pos_r;
  heap_entry_t        ent_r;
  heap_entry_t        rd_a_r, rd_b_r;
  logic [RES_W-1:0]   n_r, rdptr_r;
  logic [ID_W-1:0]    buf_rd_r;
  logic [FLAG_N-1:0]  flags_r;

  logic                  out_valid_r;
  logic                  out_fired_r, out_status_r, out_empty_r, out_last_r;
  logic [ID_W-1:0]       out_id_r;
  logic [EXP_W-1:0]      out_nd_r;

  // Heap index arithmetic around the hole position.
  logic [IDX_W:0]   c_full, c1_full;
  logic [IDX_W-1:0] c_lo, c1_lo, up_idx, rd_a_addr, rd_b_addr, sel_idx;
  logic             has_a, has_b, pick_b;
  heap_entry_t      sel;
  logic [EXP_W:0]   sum;
  logic             id_ok, cur_ok, top_live;
  logic             out_free, em_last;

  assign c_full  = {pos_r, 1'b1};
  assign c1_full = c_full + (IDX_W+1)'(1);
  assign c_lo    = c_full[IDX_W-1:0];
  assign c1_lo   = c1_full[IDX_W-1:0];
  assign has_a   = CW'(c_full) < CW'(count_r);
  assign has_b   = CW'(c1_full) < CW'(count_r);
  assign up_idx  = IDX_W'((pos_r - IDX_W'(1)) >> 1);
  assign pick_b  = has_b && (rd_a_r.expiry > rd_b_r.expiry);
  assign sel     = pick_b ? rd_b_r : rd_a_r;
  assign sel_idx = pick_b ? c1_lo : c_lo;

  assign sum    = {1'b0, now_r} + (EXP_W+1)'(delay_r);
  assign id_ok  = 32'(id_r) < ID_COUNT;
  assign cur_ok = 32'(rd_a_r.id) < ID_COUNT;
  assign top_live = !(cur_ok && flags_r[rd_a_r.id[FLAG_W-1:0]]);

  assign out_free = !out_valid_r || out_tready;
  assign em_last  = (rdptr_r + RES_W'(1)) == n_r;

  always_comb begin
    rd_a_addr = '0;
    unique case (cmd)
      CMD_UP_READ: rd_a_addr = up_idx;
      CMD_POP:     rd_a_addr = IDX_W'(count_r - CNT_W'(1));
      CMD_DN_READ: rd_a_addr = c_lo;
      default:     rd_a_addr = '0;
    endcase
  end
  assign rd_b_addr = c1_lo;

  always_comb begin
    stat.op           = op_t'(op_r);
    stat.full         = count_r == CNT_W'(CAPACITY);
    stat.pos_zero     = pos_r == '0;
    stat.up_stop      = rd_a_r.expiry <= ent_r.expiry;
    stat.count_zero   = count_r == '0;
    stat.pop_ok       = (count_r != '0) && (n_r < RES_W'(MAX_RESULTS))
                        && (rd_a_r.expiry <= now_r);
    stat.child_exists = has_a;
    stat.dn_move      = sel.expiry < ent_r.expiry;
    stat.n_zero       = n_r == '0;
    stat.em_last      = em_last;
    stat.out_free     = out_free;
  end

  // Heap memory: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    unique case (cmd)
      CMD_UP_PLACE, CMD_DN_PLACE: heap_mem[pos_r] <= ent_r;
      CMD_UP_MOVE:                heap_mem[pos_r] <= rd_a_r;
      CMD_DN_MOVE:                heap_mem[pos_r] <= sel;
      default: ;
    endcase
    if (cmd == CMD_UP_READ || cmd == CMD_TOP_READ || cmd == CMD_POP ||
        cmd == CMD_DN_READ) begin
      rd_a_r <= heap_mem[rd_a_addr];
      rd_b_r <= heap_mem[rd_b_addr];
    end
  end

  // Fired-id buffer, drained after the tick has finished popping.
  always_ff @(posedge clk) begin
    if (cmd == CMD_POP && top_live) begin
      buf_mem[n_r[BUF_AW-1:0]] <= rd_a_r.id;
    end
    if (em_cmd == EM_BUF_READ) begin
      buf_rd_r <= buf_mem[rdptr_r[BUF_AW-1:0]];
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    unique case (cmd)
      CMD_LOAD: begin
        op_r    <= in_tdata[1:0];
        now_r   <= in_tdata[33:2];
        delay_r <= in_tdata[49:34];
        id_r    <= in_tdata[57:50];
        nd_r    <= '0;
      end
      CMD_ADD_START: begin
        ent_r.expiry <= sum[EXP_W] ? {EXP_W{1'b1}} : sum[EXP_W-1:0];
        ent_r.id     <= id_r;
        pos_r        <= IDX_W'(count_r);
      end
      CMD_UP_MOVE: pos_r <= up_idx;
      CMD_TK_START: begin
        n_r     <= '0;
        rdptr_r <= '0;
      end
      CMD_POP: begin
        pos_r <= '0;
        if (top_live) begin
          n_r <= n_r + RES_W'(1);
        end
      end
      CMD_DN_LOAD: ent_r <= rd_a_r;
      CMD_DN_MOVE: pos_r <= sel_idx;
      CMD_TK_FIN: begin
        if (count_r == '0) begin
          nd_r <= EXP_W'(idle_period_r);
        end else if (rd_a_r.expiry > now_r) begin
          nd_r <= rd_a_r.expiry - now_r;
        end else begin
          nd_r <= '0;
        end
      end
      default: ;
    endcase
    if (em_cmd == EM_FIRED) begin
      rdptr_r <= rdptr_r + RES_W'(1);
    end
  end

  // Control state: entry count, status flag, cancel flags, idle period.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r       <= '0;
      full_r        <= 1'b0;
      flags_r       <= '0;
      idle_period_r <= IDLE_PERIOD_RST;
    end else begin
      if (cfg_wr_en) begin
        idle_period_r <= cfg_wr_data;
      end
      unique case (cmd)
        CMD_LOAD:     full_r <= 1'b0;
        CMD_SET_FULL: full_r <= 1'b1;
        CMD_ADD_START: begin
          count_r <= count_r + CNT_W'(1);
          if (id_ok) begin
            flags_r[id_r[FLAG_W-1:0]] <= 1'b0;
          end
        end
        CMD_CANCEL: begin
          if (id_ok) begin
            flags_r[id_r[FLAG_W-1:0]] <= 1'b1;
          end
        end
        CMD_POP: count_r <= count_r - CNT_W'(1);
        default: ;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (em_cmd == EM_RESP || em_cmd == EM_FIRED) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (em_cmd == EM_RESP) begin
      out_fired_r  <= 1'b0;
      out_id_r     <= '0;
      out_status_r <= full_r;
      out_empty_r  <= count_r == '0;
      out_nd_r     <= nd_r;
      out_last_r   <= 1'b1;
    end else if (em_cmd == EM_FIRED) begin
      out_fired_r  <= 1'b1;
      out_id_r     <= buf_rd_r;
      out_status_r <= 1'b0;
      out_empty_r  <= count_r == '0;
      out_nd_r     <= em_last ? nd_r : '0;
      out_last_r   <= em_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {5'd0, out_nd_r, out_empty_r, out_status_r, out_id_r, out_fired_r};

endmodule

// ===== src/min_heap_timer_queue_core.sv =====
// An add sifts the new entry up past each later parent. A tick pops due entries,
// sifting each replacement down, then sends one result per fired timer, or one if none fired.
// One word at a time; the next is accepted once the last result has loaded.
// Reset (rst_n, synchronous): heap empty, all cancel flags clear, idle period 5.
// ----------------------------------------------------------------------------
// min_heap_timer_queue_core
// Timer queue kept as a binary min-heap with lazy cancel and tick popping.
// ----------------------------------------------------------------------------
module min_heap_timer_queue_core
  import mhtq_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY,
  parameter int ID_COUNT = DEF_ID_COUNT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // operation[1:0], now[33:2], delay[49:34], timer_id[57:50]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // fired[0], fired_id[8:1], status[9], queue_empty[10], next_delay[42:11]
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_wr_en,
  input  logic [IDLE_W-1:0]     cfg_wr_data
);

  cmd_t     cmd;
  em_cmd_t  em_cmd;
  dp_stat_t stat;

  mhtq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd),
    .em_cmd    (em_cmd)
  );

  mhtq_datapath #(
    .CAPACITY (CAPACITY),
    .ID_COUNT (ID_COUNT)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .em_cmd      (em_cmd),
    .stat        (stat),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the min-heap timer queue. A directed table covers
// saturation, cancel, re-add, idle ticks and the unused opcode. Random add,
// cancel and tick traffic then runs under several idle periods, including a
// run that fills the heap and drains it in one tick. Every result word is
// compared against a heap model kept inside the bench.
// ----------------------------------------------------------------------------
module tb
  import mhtq_pkg::*;
();

  localparam int CAP       = DEF_CAPACITY;
  localparam int IDS       = DEF_ID_COUNT;
  localparam int STALL_MAX = 20000;

  typedef struct {
    logic             fired;
    logic [ID_W-1:0]  fid;
    logic             status;
    logic             qempty;
    logic [EXP_W-1:0] nd;
    logic             last;
  } timer_result_t;

  typedef struct {
    op_t              op;
    logic [EXP_W-1:0] now;
    logic [15:0]      dly;
    logic [ID_W-1:0]  id;
    bit               typed;
    logic             qempty;
    logic [EXP_W-1:0] nd;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic                  cfg_wr_en;
  logic [IDLE_W-1:0]     cfg_wr_data;

  min_heap_timer_queue_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast), .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  // Model state of the queue.
  heap_entry_t       heap_q [CAP];
  int unsigned       heap_cnt;
  bit [IDS-1:0]      dead_ids;
  logic [IDLE_W-1:0] idle_per;

  timer_result_t pending_results[$];
  int  errors;
  int  words_sent;
  int  timers_fired;
  int  full_rejects;
  int  hold_req;
  bit  no_gap;
  int  quiet_cycles = 0;
  logic [EXP_W-1:0] clock_base;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic timer_result_t mk_result(logic f, logic [7:0] i, logic s,
                                              logic [31:0] nd, logic l);
    timer_result_t r;
    r.fired = f; r.fid = i; r.status = s; r.qempty = (heap_cnt == 0);
    r.nd = nd; r.last = l;
    return r;
  endfunction

  task automatic heap_insert(heap_entry_t e);
    int unsigned pos, up;
    pos = heap_cnt;
    heap_cnt++;
    while (pos > 0) begin
      up = (pos - 1) / 2;
      if (heap_q[up].expiry <= e.expiry) break;
      heap_q[pos] = heap_q[up];
      pos = up;
    end
    heap_q[pos] = e;
  endtask

  task automatic heap_pop();
    int unsigned p, c;
    heap_entry_t t;
    heap_cnt--;
    heap_q[0] = heap_q[heap_cnt];
    p = 0;
    c = 1;
    while (c < heap_cnt) begin
      if (c + 1 < heap_cnt && heap_q[c].expiry > heap_q[c+1].expiry) c++;
      if (heap_q[c].expiry < heap_q[p].expiry) begin
        t = heap_q[p]; heap_q[p] = heap_q[c]; heap_q[c] = t;
        p = c;
        c = 2 * p + 1;
      end else begin
        break;
      end
    end
  endtask

  // Applies one accepted word to the model and queues the results it causes.
  task automatic predict_timer_word(op_t op, logic [31:0] now, logic [15:0] dly,
                                    logic [7:0] id);
    heap_entry_t e;
    logic [32:0] sum;
    logic [31:0] nd;
    logic [7:0]  fired_list[$];
    case (op)
      OP_ADD: begin
        if (heap_cnt >= CAP) begin
          pending_results.push_back(mk_result(0, 0, 1, 0, 1));
          full_rejects++;
        end else begin
          sum = {1'b0, now} + dly;
          e.expiry = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
          e.id = id;
          dead_ids[id] = 1'b0;
          heap_insert(e);
          pending_results.push_back(mk_result(0, 0, 0, 0, 1));
        end
      end
      OP_CANCEL: begin
        dead_ids[id] = 1'b1;
        pending_results.push_back(mk_result(0, 0, 0, 0, 1));
      end
      OP_TICK: begin
        while (heap_cnt > 0 && fired_list.size() < MAX_RESULTS &&
               heap_q[0].expiry <= now) begin
          e = heap_q[0];
          heap_pop();
          if (!dead_ids[e.id]) fired_list.push_back(e.id);
        end
        if (heap_cnt == 0) nd = idle_per;
        else nd = (heap_q[0].expiry > now) ? heap_q[0].expiry - now : 0;
        if (fired_list.size() == 0) begin
          pending_results.push_back(mk_result(0, 0, 0, nd, 1));
        end
        foreach (fired_list[k]) begin
          if (k == fired_list.size() - 1)
            pending_results.push_back(mk_result(1, fired_list[k], 0, nd, 1));
          else
            pending_results.push_back(mk_result(1, fired_list[k], 0, 0, 0));
        end
        timers_fired += fired_list.size();
      end
      default: begin
        pending_results.push_back(mk_result(0, 0, 0, 0, 1));
      end
    endcase
  endtask

  task automatic send_word(op_t op, logic [31:0] now, logic [15:0] dly,
                           logic [7:0] id);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  <= {6'b0, id, dly, now, op};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    predict_timer_word(op, now, dly, id);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_idle_period(logic [15:0] v);
    wait_drained();
    cfg_wr_data <= v;
    cfg_wr_en   <= 1'b1;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    idle_per = v;
  endtask

  // Mostly coherent traffic around a moving clock, with some wild words mixed in.
  task automatic random_traffic(int n);
    int sel;
    logic [31:0] now;
    logic [15:0] dly;
    logic [7:0]  id;
    repeat (n) begin
      sel = $urandom_range(0, 99);
      now = ($urandom_range(0, 9) == 0) ? $urandom : clock_base;
      dly = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 30));
      id  = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
      if (sel < 48) begin
        send_word(OP_ADD, now, dly, id);
      end else if (sel < 63) begin
        send_word(OP_CANCEL, now, dly, id);
      end else if (sel < 97) begin
        clock_base += $urandom_range(0, 20);
        send_word(OP_TICK, ($urandom_range(0, 9) == 0) ? now : clock_base, dly, id);
      end else begin
        send_word(OP_NONE, now, dly, id);
      end
    end
  endtask

  // Result side: random stalls, plus a long hold-off on request.
  initial begin
    int stall;
    out_tready <= 1'b0;
    @(negedge clk);
    forever begin
      stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
      if (hold_req > 0) begin
        stall = hold_req;
        hold_req = 0;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    timer_result_t want;
    if (out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: %h last %b", out_tdata, out_tlast);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[0] !== want.fired) begin
          $error("fired: expected %0d actual %0d", want.fired, out_tdata[0]); errors++;
        end
        if (out_tdata[8:1] !== want.fid) begin
          $error("fired_id: expected %0d actual %0d", want.fid, out_tdata[8:1]); errors++;
        end
        if (out_tdata[9] !== want.status) begin
          $error("status: expected %0d actual %0d", want.status, out_tdata[9]); errors++;
        end
        if (out_tdata[10] !== want.qempty) begin
          $error("queue_empty: expected %0d actual %0d", want.qempty, out_tdata[10]);
          errors++;
        end
        if (out_tdata[42:11] !== want.nd) begin
          $error("next_delay: expected %0d actual %0d", want.nd, out_tdata[42:11]);
          errors++;
        end
        if (out_tlast !== want.last) begin
          $error("last: expected %0d actual %0d", want.last, out_tlast); errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted word.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_MAX) begin
      $display("FAILURE");
      $finish;
    end
  end

  stim_row_t directed[] = '{
    '{OP_TICK,   32'd0,          16'd0,     8'd0,   1, 1'b1, 32'd5},
    '{OP_ADD,    32'hFFFF_FFF0,  16'hFFFF,  8'hFF,  1, 1'b0, 32'd0},
    '{OP_CANCEL, 32'd0,          16'd0,     8'hFF,  1, 1'b0, 32'd0},
    '{OP_TICK,   32'hFFFF_FFFF,  16'd0,     8'd0,   1, 1'b1, 32'd5},
    '{OP_NONE,   32'hFFFF_FFFF,  16'hFFFF,  8'hFF,  1, 1'b1, 32'd0},
    '{OP_ADD,    32'd100,        16'd0,     8'd0,   0, 1'b0, 32'd0},
    '{OP_ADD,    32'd100,        16'd10,    8'd1,   0, 1'b0, 32'd0},
    '{OP_ADD,    32'd100,        16'd5,     8'd2,   0, 1'b0, 32'd0},
    '{OP_CANCEL, 32'd0,          16'd0,     8'd1,   0, 1'b0, 32'd0},
    '{OP_ADD,    32'd100,        16'd20,    8'd1,   0, 1'b0, 32'd0},
    '{OP_ADD,    32'd100,        16'd3,     8'd7,   0, 1'b0, 32'd0},
    '{OP_CANCEL, 32'd0,          16'd0,     8'd7,   0, 1'b0, 32'd0},
    '{OP_TICK,   32'd100,        16'd0,     8'd0,   0, 1'b0, 32'd0},
    '{OP_TICK,   32'd104,        16'd0,     8'd0,   0, 1'b0, 32'd0},
    '{OP_TICK,   32'd200,        16'd0,     8'd0,   0, 1'b0, 32'd0},
    '{OP_TICK,   32'd300,        16'd0,     8'd0,   1, 1'b1, 32'd5},
    '{OP_ADD,    32'hAAAA_5555,  16'h5AA5,  8'hA5,  0, 1'b0, 32'd0},
    '{OP_ADD,    32'h5555_AAAA,  16'hA55A,  8'h5A,  0, 1'b0, 32'd0},
    '{OP_TICK,   32'hFFFF_FFFF,  16'd0,     8'd0,   0, 1'b0, 32'd0}
  };

  initial begin
    timer_result_t typed_res;
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0;
    cfg_wr_en = 1'b0; cfg_wr_data = '0;
    errors = 0; words_sent = 0; timers_fired = 0; full_rejects = 0;
    hold_req = 0; no_gap = 0;
    heap_cnt = 0; dead_ids = '0; idle_per = IDLE_PERIOD_RST;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // Rows with a typed answer replace the model's single result with it.
    foreach (directed[i]) begin
      send_word(directed[i].op, directed[i].now, directed[i].dly, directed[i].id);
      if (directed[i].typed) begin
        typed_res = '{0, 0, 0, directed[i].qempty, directed[i].nd, 1};
        void'(pending_results.pop_back());
        pending_results.push_back(typed_res);
      end
    end

    write_idle_period(16'd0);
    clock_base = 32'd1000;
    random_traffic(15);

    // Fill the heap back to back while results are held off, then drain it.
    write_idle_period(16'hFFFF);
    hold_req = 400;
    no_gap = 1;
    repeat (CAP + 2) send_word(OP_ADD, clock_base, 16'($urandom_range(0, 40)), 8'($urandom));
    no_gap = 0;
    wait_drained();
    send_word(OP_TICK, 32'hFFFF_FFFF, 16'd0, 8'd0);

    clock_base = 32'hFFFF_FF00;
    random_traffic(15);
    write_idle_period(16'($urandom));
    clock_base = $urandom;
    random_traffic(15);

    wait_drained();
    repeat (40) @(negedge clk);
    $display("Sent %0d words under four idle periods, including a full heap.", words_sent);
    $display("%0d timers fired, %0d adds refused as full.", timers_fired, full_rejects);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
